// ===== rtl/gnss_binary_frame_parser_unit_assert.svh =====
// Assertion macros for the frame parser unit.
// Used by the top level; no other dependencies.
`ifndef GNSS_BINARY_FRAME_PARSER_UNIT_ASSERT_SVH
`define GNSS_BINARY_FRAME_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define GBFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");

// next-cycle implication
`define GBFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`endif

// ===== rtl/gbfp_pkg.sv =====
// Shared types and constants of the frame parser unit.
// No dependencies.
package gbfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] CLASS_NAV   = 8'h01;
    localparam logic [7:0] ID_POSLLH   = 8'h02;
    localparam logic [7:0] ID_PVT      = 8'h07;

    localparam logic [15:0] POSLLH_MIN_LEN = 16'd28;
    localparam logic [15:0] PVT_MIN_LEN    = 16'd48;
    localparam logic [15:0] PVT_ITOW_END   = 16'd4;
    localparam logic [15:0] PVT_POS_START  = 16'd24;

    localparam int FIELD_COUNT = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] SLOT_NONE = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CHECKSUM  = 2'd1;
    localparam logic [1:0] ST_UNSUPPORT = 2'd2;
    localparam logic [1:0] ST_SHORT     = 2'd3;

    typedef enum logic [2:0] {
        K_CLASS,
        K_ID,
        K_LEN_LO,
        K_LEN_HI,
        K_PAYLOAD,
        K_CK_A,
        K_CK_B
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [2:0] slot;
        logic [1:0] lane;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/gbfp_front.sv =====
// Front end: sync hunt, length tracking and byte classification.
// Depends on gbfp_pkg.
module gbfp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              push,
    output gbfp_pkg::entry_t  entry
);

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] cnt_inc;
    logic [15:0] pvt_off_wide;
    logic [4:0]  pvt_off;
    logic [2:0]  slot;
    logic [1:0]  lane;

    always_comb
    begin
        pvt_off_wide = cnt_reg - gbfp_pkg::PVT_POS_START;
        pvt_off      = pvt_off_wide[4:0];
        slot         = gbfp_pkg::SLOT_NONE;
        lane         = cnt_reg[1:0];
        if (class_reg == gbfp_pkg::CLASS_NAV)
        begin
            if (id_reg == gbfp_pkg::ID_POSLLH)
            begin
                if (cnt_reg < gbfp_pkg::POSLLH_MIN_LEN)
                begin
                    slot = cnt_reg[4:2];
                end
            end
            else if (id_reg == gbfp_pkg::ID_PVT)
            begin
                if (cnt_reg < gbfp_pkg::PVT_ITOW_END)
                begin
                    slot = 3'd0;
                end
                else if (cnt_reg >= gbfp_pkg::PVT_POS_START &&
                         cnt_reg < gbfp_pkg::PVT_MIN_LEN)
                begin
                    slot = 3'd1 + pvt_off[4:2];
                    lane = pvt_off[1:0];
                end
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        cnt_inc    = cnt_reg + 16'd1;
        push       = 1'b0;
        entry.kind = gbfp_pkg::K_PAYLOAD;
        entry.data = rx_byte;
        entry.slot = gbfp_pkg::SLOT_NONE;
        entry.lane = 2'd0;
        if (accept)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == gbfp_pkg::SYNC_SECOND)
                        phase_next = PH_CLASS;
                    else if (rx_byte != gbfp_pkg::SYNC_FIRST)
                        phase_next = PH_SYNC1;
                end
                PH_CLASS:
                begin
                    class_next = rx_byte;
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_CLASS;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next    = rx_byte;
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_ID;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'd0, rx_byte};
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_LEN_LO;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {rx_byte, len_reg[7:0]};
                    cnt_next   = 16'd0;
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_LEN_HI;
                    phase_next = ({rx_byte, len_reg[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_PAYLOAD;
                    entry.slot = slot;
                    entry.lane = lane;
                    cnt_next   = cnt_inc;
                    if (cnt_inc == len_reg)
                        phase_next = PH_CK_A;
                end
                PH_CK_A:
                begin
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_CK_A;
                    phase_next = PH_CK_B;
                end
                PH_CK_B:
                begin
                    push       = 1'b1;
                    entry.kind = gbfp_pkg::K_CK_B;
                    phase_next = PH_SYNC1;
                end
                default:
                begin
                    phase_next = (rx_byte == gbfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            class_reg <= 8'd0;
            id_reg    <= 8'd0;
            len_reg   <= 16'd0;
            cnt_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/gbfp_queue.sv =====
// Short queue of classified items between front and back.
// Depends on gbfp_pkg.
module gbfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gbfp_pkg::entry_t  push_entry,
    input  logic              pop,
    output gbfp_pkg::entry_t  head,
    output gbfp_pkg::qstat_t  stat
);

    gbfp_pkg::entry_t                  mem_reg [gbfp_pkg::QUEUE_DEPTH];
    logic [gbfp_pkg::QPTR_W-1:0]       wr_reg, wr_next;
    logic [gbfp_pkg::QPTR_W-1:0]       rd_reg, rd_next;
    logic [gbfp_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    always_comb
    begin
        stat.full  = (cnt_reg == gbfp_pkg::QCNT_W'(gbfp_pkg::QUEUE_DEPTH));
        stat.empty = (cnt_reg == '0);
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        wr_next    = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next   = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
        head = mem_reg[rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/gbfp_back.sv =====
// Back end: checksum, field capture, status and the result register.
// Depends on gbfp_pkg.
module gbfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  gbfp_pkg::entry_t    head,
    input  logic                head_valid,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [1:0]          status,
    output logic [7:0]          message_class,
    output logic [7:0]          message_id,
    output logic [31:0]         time_of_week,
    output logic signed [31:0]  longitude,
    output logic signed [31:0]  latitude,
    output logic signed [31:0]  ellipsoid_height,
    output logic signed [31:0]  sea_level_height,
    output logic [31:0]         horizontal_accuracy,
    output logic [31:0]         vertical_accuracy
);

    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  sent_a_reg, sent_a_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] fields_reg [gbfp_pkg::FIELD_COUNT];
    logic [31:0] fields_next [gbfp_pkg::FIELD_COUNT];
    logic        res_valid_reg, res_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  oclass_reg, oclass_next;
    logic [7:0]  oid_reg, oid_next;
    logic [31:0] odata_reg [gbfp_pkg::FIELD_COUNT];
    logic [31:0] odata_next [gbfp_pkg::FIELD_COUNT];
    logic [7:0]  add_a;
    logic        emit;

    always_comb
    begin
        pop    = head_valid &&
                 (head.kind != gbfp_pkg::K_CK_B || !res_valid_reg || res_ready);
        emit   = pop && head.kind == gbfp_pkg::K_CK_B;
        add_a  = sum_a_reg + head.data;

        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        sent_a_next = sent_a_reg;
        class_next  = class_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        fields_next = fields_reg;
        status_next = status_reg;
        oclass_next = oclass_reg;
        oid_next    = oid_reg;
        odata_next  = odata_reg;
        res_valid_next = (res_valid_reg && !res_ready) || emit;

        if (pop)
        begin
            case (head.kind)
                gbfp_pkg::K_CLASS:
                begin
                    class_next = head.data;
                    sum_a_next = head.data;
                    sum_b_next = head.data;
                    for (int i = 0; i < gbfp_pkg::FIELD_COUNT; i++)
                        fields_next[i] = 32'd0;
                end
                gbfp_pkg::K_ID:
                begin
                    id_next    = head.data;
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                end
                gbfp_pkg::K_LEN_LO:
                begin
                    len_next   = {8'd0, head.data};
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                end
                gbfp_pkg::K_LEN_HI:
                begin
                    len_next   = {head.data, len_reg[7:0]};
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                end
                gbfp_pkg::K_PAYLOAD:
                begin
                    sum_a_next = add_a;
                    sum_b_next = sum_b_reg + add_a;
                    for (int i = 0; i < gbfp_pkg::FIELD_COUNT; i++)
                    begin
                        if (head.slot == 3'(i))
                            fields_next[i][head.lane*8 +: 8] = head.data;
                    end
                end
                gbfp_pkg::K_CK_A:
                begin
                    sent_a_next = head.data;
                end
                gbfp_pkg::K_CK_B:
                begin
                    if (sent_a_reg != sum_a_reg || head.data != sum_b_reg)
                        status_next = gbfp_pkg::ST_CHECKSUM;
                    else if (class_reg == gbfp_pkg::CLASS_NAV &&
                             id_reg == gbfp_pkg::ID_POSLLH)
                        status_next = (len_reg < gbfp_pkg::POSLLH_MIN_LEN) ?
                                      gbfp_pkg::ST_SHORT : gbfp_pkg::ST_OK;
                    else if (class_reg == gbfp_pkg::CLASS_NAV &&
                             id_reg == gbfp_pkg::ID_PVT)
                        status_next = (len_reg < gbfp_pkg::PVT_MIN_LEN) ?
                                      gbfp_pkg::ST_SHORT : gbfp_pkg::ST_OK;
                    else
                        status_next = gbfp_pkg::ST_UNSUPPORT;
                    oclass_next = class_reg;
                    oid_next    = id_reg;
                    for (int i = 0; i < gbfp_pkg::FIELD_COUNT; i++)
                        odata_next[i] = (status_next == gbfp_pkg::ST_OK) ?
                                        fields_reg[i] : 32'd0;
                end
                default:
                begin
                    sent_a_next = sent_a_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            sent_a_reg    <= 8'd0;
            class_reg     <= 8'd0;
            id_reg        <= 8'd0;
            len_reg       <= 16'd0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            sent_a_reg    <= sent_a_next;
            class_reg     <= class_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fields_reg <= fields_next;
        status_reg <= status_next;
        oclass_reg <= oclass_next;
        oid_reg    <= oid_next;
        odata_reg  <= odata_next;
    end

    assign res_valid           = res_valid_reg;
    assign status              = status_reg;
    assign message_class       = oclass_reg;
    assign message_id          = oid_reg;
    assign time_of_week        = odata_reg[0];
    assign longitude           = odata_reg[1];
    assign latitude            = odata_reg[2];
    assign ellipsoid_height    = odata_reg[3];
    assign sea_level_height    = odata_reg[4];
    assign horizontal_accuracy = odata_reg[5];
    assign vertical_accuracy   = odata_reg[6];

endmodule

// ===== rtl/gnss_binary_frame_parser_unit.sv =====
// Top level of the binary frame parser: front end, item queue, back end.
// Depends on gbfp_pkg, gbfp_front, gbfp_queue, gbfp_back and the assertion header.
//
// Takes one byte per cycle on rx_valid/rx_ready while the queue has room and registers
// one result per completed frame once its second checksum byte leaves the four-entry
// item queue. The front end tracks sync, length and payload offset; the back end keeps
// the Fletcher sums and captured fields and owns the result register. A held result
// stalls only the back end; the front keeps taking bytes until the queue fills.
`include "gnss_binary_frame_parser_unit_assert.svh"

module gnss_binary_frame_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [1:0]          status,
    output logic [7:0]          message_class,
    output logic [7:0]          message_id,
    output logic [31:0]         time_of_week,
    output logic signed [31:0]  longitude,
    output logic signed [31:0]  latitude,
    output logic signed [31:0]  ellipsoid_height,
    output logic signed [31:0]  sea_level_height,
    output logic [31:0]         horizontal_accuracy,
    output logic [31:0]         vertical_accuracy
);

    logic              push;
    logic              pop;
    gbfp_pkg::entry_t  push_entry;
    gbfp_pkg::entry_t  head;
    gbfp_pkg::qstat_t  qstat;

    assign rx_ready = !qstat.full;

    gbfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (rx_valid && rx_ready),
        .rx_byte (rx_byte),
        .push    (push),
        .entry   (push_entry)
    );

    gbfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (qstat)
    );

    gbfp_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (head),
        .head_valid          (!qstat.empty),
        .pop                 (pop),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .status              (status),
        .message_class       (message_class),
        .message_id          (message_id),
        .time_of_week        (time_of_week),
        .longitude           (longitude),
        .latitude            (latitude),
        .ellipsoid_height    (ellipsoid_height),
        .sea_level_height    (sea_level_height),
        .horizontal_accuracy (horizontal_accuracy),
        .vertical_accuracy   (vertical_accuracy)
    );

    `GBFP_ASSERT_NOW(a_zero_unless_ok, clk, rst_n,
        res_valid && status != gbfp_pkg::ST_OK,
        time_of_week == 32'd0 && longitude == 32'sd0 && latitude == 32'sd0 &&
        ellipsoid_height == 32'sd0 && sea_level_height == 32'sd0 &&
        horizontal_accuracy == 32'd0 && vertical_accuracy == 32'd0)
    `GBFP_ASSERT_NOW(a_ok_is_known_msg, clk, rst_n,
        res_valid && status == gbfp_pkg::ST_OK,
        message_class == gbfp_pkg::CLASS_NAV &&
        (message_id == gbfp_pkg::ID_POSLLH || message_id == gbfp_pkg::ID_PVT))
    `GBFP_ASSERT_NEXT(a_result_from_ckb, clk, rst_n,
        !res_valid && !(pop && head.kind == gbfp_pkg::K_CK_B),
        !res_valid)
    `GBFP_ASSERT_NOW(a_no_push_when_full, clk, rst_n,
        qstat.full, !push)

endmodule

// ===== tb/gnss_binary_frame_parser_checker.sv =====
// Checker for the binary frame parser: predicts one result per completed frame
// from the accepted bytes and compares every accepted result. Depends on gbfp_pkg.
`timescale 1ns / 100ps

module gnss_binary_frame_parser_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic [1:0]         status,
    input  logic [7:0]         message_class,
    input  logic [7:0]         message_id,
    input  logic [31:0]        time_of_week,
    input  logic signed [31:0] longitude,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] ellipsoid_height,
    input  logic signed [31:0] sea_level_height,
    input  logic [31:0]        horizontal_accuracy,
    input  logic [31:0]        vertical_accuracy,
    output int                 failure_count,
    output int                 results_pending
);

    typedef enum logic [3:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        TAKE_CLASS,
        TAKE_ID,
        TAKE_LEN_LO,
        TAKE_LEN_HI,
        TAKE_PAYLOAD,
        TAKE_CK_A,
        TAKE_CK_B
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       msg_class;
        logic [7:0]       msg_id;
        logic [6:0][31:0] fields;
    } frame_result_t;

    string field_names[7] = '{"time_of_week", "longitude", "latitude", "ellipsoid_height",
                              "sea_level_height", "horizontal_accuracy", "vertical_accuracy"};

    parse_phase_t     phase;
    logic [7:0]       held_class;
    logic [7:0]       held_id;
    logic [15:0]      frame_length;
    logic [15:0]      byte_count;
    logic [7:0]       sum_a;
    logic [7:0]       sum_b;
    logic [7:0]       sent_sum_a;
    logic [6:0][31:0] field_store;
    frame_result_t    expected_frames[$];

    task automatic reset_parser();
        phase        = HUNT_SYNC1;
        held_class   = '0;
        held_id      = '0;
        frame_length = '0;
        byte_count   = '0;
        sum_a        = '0;
        sum_b        = '0;
        sent_sum_a   = '0;
        field_store  = '0;
        expected_frames.delete();
    endtask

    task automatic add_to_sums(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    task automatic store_payload_byte(input logic [15:0] offset, input logic [7:0] b);
        int slot;
        int lane;
        slot = -1;
        lane = 0;
        if (held_class == gbfp_pkg::CLASS_NAV && held_id == gbfp_pkg::ID_POSLLH &&
            offset < gbfp_pkg::POSLLH_MIN_LEN)
        begin
            slot = int'(offset) / 4;
            lane = int'(offset) % 4;
        end
        else if (held_class == gbfp_pkg::CLASS_NAV && held_id == gbfp_pkg::ID_PVT)
        begin
            if (offset < gbfp_pkg::PVT_ITOW_END)
            begin
                slot = 0;
                lane = int'(offset);
            end
            else if (offset >= gbfp_pkg::PVT_POS_START && offset < gbfp_pkg::PVT_MIN_LEN)
            begin
                slot = 1 + int'(offset - gbfp_pkg::PVT_POS_START) / 4;
                lane = int'(offset - gbfp_pkg::PVT_POS_START) % 4;
            end
        end
        if (slot >= 0)
            field_store[slot][lane*8 +: 8] = b;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        frame_result_t res;
        case (phase)
            HUNT_SYNC2:
            begin
                if (b == gbfp_pkg::SYNC_SECOND)
                    phase = TAKE_CLASS;
                else if (b != gbfp_pkg::SYNC_FIRST)
                    phase = HUNT_SYNC1;
            end
            TAKE_CLASS:
            begin
                held_class  = b;
                sum_a       = '0;
                sum_b       = '0;
                add_to_sums(b);
                field_store = '0;
                phase       = TAKE_ID;
            end
            TAKE_ID:
            begin
                held_id = b;
                add_to_sums(b);
                phase   = TAKE_LEN_LO;
            end
            TAKE_LEN_LO:
            begin
                frame_length = {8'h00, b};
                add_to_sums(b);
                phase        = TAKE_LEN_HI;
            end
            TAKE_LEN_HI:
            begin
                frame_length[15:8] = b;
                add_to_sums(b);
                byte_count = '0;
                phase      = (frame_length == 16'd0) ? TAKE_CK_A : TAKE_PAYLOAD;
            end
            TAKE_PAYLOAD:
            begin
                add_to_sums(b);
                store_payload_byte(byte_count, b);
                byte_count = byte_count + 16'd1;
                if (byte_count == frame_length)
                    phase = TAKE_CK_A;
            end
            TAKE_CK_A:
            begin
                sent_sum_a = b;
                phase      = TAKE_CK_B;
            end
            TAKE_CK_B:
            begin
                if (sent_sum_a != sum_a || b != sum_b)
                    res.status = gbfp_pkg::ST_CHECKSUM;
                else if (held_class == gbfp_pkg::CLASS_NAV && held_id == gbfp_pkg::ID_POSLLH)
                    res.status = (frame_length < gbfp_pkg::POSLLH_MIN_LEN) ?
                                 gbfp_pkg::ST_SHORT : gbfp_pkg::ST_OK;
                else if (held_class == gbfp_pkg::CLASS_NAV && held_id == gbfp_pkg::ID_PVT)
                    res.status = (frame_length < gbfp_pkg::PVT_MIN_LEN) ?
                                 gbfp_pkg::ST_SHORT : gbfp_pkg::ST_OK;
                else
                    res.status = gbfp_pkg::ST_UNSUPPORT;
                res.msg_class = held_class;
                res.msg_id    = held_id;
                res.fields    = (res.status == gbfp_pkg::ST_OK) ? field_store : '0;
                expected_frames = {expected_frames, res};
                phase = HUNT_SYNC1;
            end
            default:
                phase = (b == gbfp_pkg::SYNC_FIRST) ? HUNT_SYNC2 : HUNT_SYNC1;
        endcase
    endtask

    task automatic compare_result(input frame_result_t exp);
        logic [6:0][31:0] got_fields;
        got_fields = {vertical_accuracy, horizontal_accuracy, sea_level_height,
                      ellipsoid_height, latitude, longitude, time_of_week};
        if (status !== exp.status)
        begin
            $display("%0t: status expected %0d, got %0d", $time, exp.status, status);
            failure_count++;
        end
        if (message_class !== exp.msg_class)
        begin
            $display("%0t: message_class expected %h, got %h", $time, exp.msg_class,
                     message_class);
            failure_count++;
        end
        if (message_id !== exp.msg_id)
        begin
            $display("%0t: message_id expected %h, got %h", $time, exp.msg_id, message_id);
            failure_count++;
        end
        for (int i = 0; i < gbfp_pkg::FIELD_COUNT; i++)
        begin
            if (got_fields[i] !== exp.fields[i])
            begin
                $display("%0t: %s expected %h, got %h", $time, field_names[i],
                         exp.fields[i], got_fields[i]);
                failure_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            results_pending = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: result with no frame pending: expected none, %s %0d %h %h",
                             $time, "got status/class/id", status, message_class,
                             message_id);
                    failure_count++;
                end
                else
                    compare_result(expected_frames.pop_front());
            end
            if (rx_valid && rx_ready)
                parse_rx_byte(rx_byte);
            results_pending = expected_frames.size();
        end
    end

endmodule

// ===== tb/gnss_binary_frame_parser_unit_tb.sv =====
// Top of the frame parser testbench: clock, reset, byte and result stimulus, verdict.
// Depends on gbfp_pkg, gnss_binary_frame_parser_unit and gnss_binary_frame_parser_checker.
`timescale 1ns / 100ps

module gnss_binary_frame_parser_unit_tb;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BYTES     = 220;
    localparam int TAIL_CYCLES     = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [1:0]         status;
    logic [7:0]         message_class;
    logic [7:0]         message_id;
    logic [31:0]        time_of_week;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] ellipsoid_height;
    logic signed [31:0] sea_level_height;
    logic [31:0]        horizontal_accuracy;
    logic [31:0]        vertical_accuracy;
    int                 failure_count;
    int                 results_pending;

    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   bytes_sent = 0;
    int   quiet_cycles = 0;
    logic hold_off_request = 1'b0;

    gnss_binary_frame_parser_unit u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rx_valid            (rx_valid),
        .rx_ready            (rx_ready),
        .rx_byte             (rx_byte),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .status              (status),
        .message_class       (message_class),
        .message_id          (message_id),
        .time_of_week        (time_of_week),
        .longitude           (longitude),
        .latitude            (latitude),
        .ellipsoid_height    (ellipsoid_height),
        .sea_level_height    (sea_level_height),
        .horizontal_accuracy (horizontal_accuracy),
        .vertical_accuracy   (vertical_accuracy)
    );

    gnss_binary_frame_parser_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rx_valid            (rx_valid),
        .rx_ready            (rx_ready),
        .rx_byte             (rx_byte),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .status              (status),
        .message_class       (message_class),
        .message_id          (message_id),
        .time_of_week        (time_of_week),
        .longitude           (longitude),
        .latitude            (latitude),
        .ellipsoid_height    (ellipsoid_height),
        .sea_level_height    (sea_level_height),
        .horizontal_accuracy (horizontal_accuracy),
        .vertical_accuracy   (vertical_accuracy),
        .failure_count       (failure_count),
        .results_pending     (results_pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((rx_valid && rx_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("gnss_binary_frame_parser_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic hold_off_done;
        hold_off_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // fill: 0 random, 1 zeros, 2 ones, 3 most negative words, 4 most positive words
    // fault: bit 0 corrupts the first checksum byte, bit 1 the second
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int fill, input int fault);
        logic [7:0] frame_bytes[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] pb;
        int         i;
        frame_bytes = '{gbfp_pkg::SYNC_FIRST, gbfp_pkg::SYNC_SECOND, cls, id,
                        len[7:0], len[15:8]};
        for (i = 0; i < int'(len); i++)
        begin
            case (fill)
                1:       pb = 8'h00;
                2:       pb = 8'hFF;
                3:       pb = (i % 4 == 3) ? 8'h80 : 8'h00;
                4:       pb = (i % 4 == 3) ? 8'h7F : 8'hFF;
                default: pb = 8'($urandom_range(255));
            endcase
            frame_bytes = {frame_bytes, pb};
        end
        ck_a = 8'h00;
        ck_b = 8'h00;
        for (i = 2; i < frame_bytes.size(); i++)
        begin
            ck_a = ck_a + frame_bytes[i];
            ck_b = ck_b + ck_a;
        end
        if (fault % 2 == 1)
            ck_a = ck_a ^ 8'($urandom_range(1, 255));
        if (fault / 2 == 1)
            ck_b = ck_b ^ 8'($urandom_range(1, 255));
        frame_bytes = {frame_bytes, ck_a, ck_b};
        foreach (frame_bytes[k])
            send_byte(frame_bytes[k]);
    endtask

    task automatic send_random_frame();
        int         roll;
        int         fill;
        int         fault;
        int         noise_count;
        logic [7:0] cls;
        logic [7:0] id;
        logic [7:0] junk;
        logic [15:0] len;
        roll = $urandom_range(99);
        if (roll < 20)
        begin
            noise_count = $urandom_range(1, 3);
            repeat (noise_count)
            begin
                junk = 8'($urandom_range(255));
                if (junk == gbfp_pkg::SYNC_FIRST)
                    junk = 8'h00;
                send_byte(junk);
            end
        end
        else if (roll < 30)
        begin
            junk = 8'($urandom_range(255));
            if (junk == gbfp_pkg::SYNC_SECOND)
                junk = gbfp_pkg::SYNC_FIRST;
            send_byte(gbfp_pkg::SYNC_FIRST);
            send_byte(junk);
        end
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            cls  = gbfp_pkg::CLASS_NAV;
            id   = gbfp_pkg::ID_POSLLH;
            roll = $urandom_range(99);
            len  = (roll < 20) ? 16'($urandom_range(27)) :
                   (roll < 85) ? gbfp_pkg::POSLLH_MIN_LEN : 16'($urandom_range(29, 40));
        end
        else if (roll < 68)
        begin
            cls  = gbfp_pkg::CLASS_NAV;
            id   = gbfp_pkg::ID_PVT;
            roll = $urandom_range(99);
            len  = (roll < 20) ? 16'($urandom_range(47)) :
                   (roll < 80) ? gbfp_pkg::PVT_MIN_LEN : 16'($urandom_range(49, 64));
        end
        else if (roll < 78)
        begin
            cls = gbfp_pkg::CLASS_NAV;
            id  = 8'($urandom_range(255));
            len = 16'($urandom_range(16));
        end
        else if (roll < 93)
        begin
            cls  = 8'($urandom_range(255));
            roll = $urandom_range(2);
            id   = (roll == 0) ? gbfp_pkg::ID_POSLLH :
                   (roll == 1) ? gbfp_pkg::ID_PVT : 8'($urandom_range(255));
            len  = 16'($urandom_range(16));
        end
        else if (roll < 95)
        begin
            cls = 8'($urandom_range(255));
            id  = 8'($urandom_range(255));
            len = 16'(256 + $urandom_range(40));
        end
        else
        begin
            cls = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
            id  = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
            len = 16'($urandom_range(8));
        end
        fill  = ($urandom_range(9) < 8) ? 0 : $urandom_range(1, 4);
        roll  = $urandom_range(99);
        fault = (roll < 8) ? 1 : (roll < 16) ? 2 : (roll < 19) ? 3 : 0;
        send_frame(cls, id, len, fill, fault);
    endtask

    initial
    begin
        int phase_start;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_POSLLH, gbfp_pkg::POSLLH_MIN_LEN, 2, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_POSLLH, gbfp_pkg::POSLLH_MIN_LEN, 1, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_PVT, gbfp_pkg::PVT_MIN_LEN, 3, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_PVT, 16'd92, 4, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_POSLLH, 16'd27, 0, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_PVT, 16'd0, 0, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_PVT, 16'd47, 0, 0);
        send_frame(gbfp_pkg::CLASS_NAV, 8'h05, 16'd4, 0, 0);
        send_frame(8'hFF, 8'hFF, 16'd0, 0, 0);
        send_frame(8'h00, 8'h00, 16'd1, 1, 0);
        send_frame(8'h02, gbfp_pkg::ID_POSLLH, gbfp_pkg::POSLLH_MIN_LEN, 0, 0);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_POSLLH, gbfp_pkg::POSLLH_MIN_LEN, 0, 1);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_PVT, gbfp_pkg::PVT_MIN_LEN, 0, 2);
        send_frame(8'h0A, 8'h04, 16'd2, 0, 3);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_POSLLH, 16'd4, 0, 1);
        send_byte(gbfp_pkg::SYNC_FIRST);
        send_byte(8'h00);
        send_byte(gbfp_pkg::SYNC_FIRST);
        send_byte(gbfp_pkg::SYNC_FIRST);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_POSLLH, gbfp_pkg::POSLLH_MIN_LEN, 0, 0);
        send_byte(8'hFF);
        send_byte(gbfp_pkg::SYNC_SECOND);
        send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_PVT, gbfp_pkg::PVT_MIN_LEN, 0, 0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 52;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 52;
                end
                default:
                begin
                    sender_idle_pct = 19;
                    recv_stall_pct  = 19;
                end
            endcase
            if (p == 0)
            begin
                hold_off_request = 1'b1;
                repeat (12)
                    send_frame(8'h0A, 8'($urandom_range(255)), 16'd0, 0, 0);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_frame();
        end

        rx_valid <= 1'b0;
        recv_stall_pct = 0;
        wait (results_pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failure_count == 0)
            $display("gnss_binary_frame_parser_unit_tb: done, clean");
        else
            $display("gnss_binary_frame_parser_unit_tb: done, errors");
        $finish;
    end

endmodule
